// ===== rtl/ffr_pkg.sv =====
package ffr_pkg;

   localparam int TAPS      = 8;
   localparam int TAP_W     = 3;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = 35;
   localparam int NUM_COEFS = 8;
   localparam int CSR_IDX_W = 4;

   typedef struct packed {
      logic start;     // write sample into ring, clear accumulator, latch indexes
      logic mul;       // multiply one tap and step the indexes
      logic out_load;  // move the sum into the result register
   } ffr_cmd_type;

   typedef struct packed {
      logic last_tap;  // the tap being multiplied is the last one
   } ffr_status_type;

endpackage

// ===== rtl/ffr_datapath.sv =====
module ffr_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ffr_pkg::ffr_cmd_type                   cmd,
   output ffr_pkg::ffr_status_type                status,
   input  logic signed [ffr_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                                   csr_write_en,
   input  logic        [ffr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic signed [ffr_pkg::COEF_W-1:0]      csr_data,
   output logic signed [ffr_pkg::ACC_W-1:0]       rsp_filtered
);

   logic signed [ffr_pkg::SAMPLE_W-1:0] ring_ff [ffr_pkg::TAPS];
   logic signed [ffr_pkg::COEF_W-1:0]   coef_ff [ffr_pkg::NUM_COEFS];
   logic        [ffr_pkg::TAP_W-1:0]    wp_ff, wp_in;
   logic        [ffr_pkg::TAP_W-1:0]    tap_ff, tap_in;
   logic        [ffr_pkg::TAP_W-1:0]    cidx_ff, cidx_in;
   logic signed [ffr_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                                prod_valid_ff, prod_valid_in;
   logic signed [ffr_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ffr_pkg::ACC_W-1:0]    out_ff, out_in;

   localparam logic [ffr_pkg::TAP_W-1:0] LAST = ffr_pkg::TAP_W'(ffr_pkg::TAPS - 1);

   assign status.last_tap = (tap_ff == LAST);
   assign rsp_filtered    = out_ff;

   always_comb begin
      wp_in         = wp_ff;
      tap_in        = tap_ff;
      cidx_in       = cidx_ff;
      prod_in       = prod_ff;
      prod_valid_in = 1'b0;
      acc_in        = acc_ff;
      out_in        = out_ff;
      if (prod_valid_ff) begin
         acc_in = acc_ff + {{(ffr_pkg::ACC_W - ffr_pkg::PROD_W){prod_ff[ffr_pkg::PROD_W-1]}},
                            prod_ff};
      end
      if (cmd.start) begin
         wp_in   = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
         tap_in  = '0;
         // oldest slot sits right after the one just written
         cidx_in = LAST - wp_ff;
         acc_in  = '0;
      end
      if (cmd.mul) begin
         prod_in       = ffr_pkg::PROD_W'(coef_ff[cidx_ff]) *
                         ffr_pkg::PROD_W'(ring_ff[tap_ff]);
         prod_valid_in = 1'b1;
         tap_in        = tap_ff + 1'b1;
         cidx_in       = (cidx_ff == LAST) ? '0 : cidx_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ffr_pkg::TAPS; i++) begin
            ring_ff[i] <= '0;
         end
         for (int i = 0; i < ffr_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
         wp_ff         <= '0;
         prod_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            ring_ff[wp_ff] <= req_sample;
         end
         // drop writes beyond the coefficient bank
         if (csr_write_en && (csr_index < ffr_pkg::CSR_IDX_W'(ffr_pkg::NUM_COEFS))) begin
            coef_ff[csr_index[ffr_pkg::TAP_W-1:0]] <= csr_data;
         end
         wp_ff         <= wp_in;
         prod_valid_ff <= prod_valid_in;
      end
      tap_ff  <= tap_in;
      cidx_ff <= cidx_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

endmodule

// ===== rtl/ffr_ctrl.sv =====
module ffr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ffr_pkg::ffr_cmd_type    cmd,
   input  ffr_pkg::ffr_status_type status
);

   typedef enum logic [1:0] {
      IDLE,
      MAC,
      DRAIN,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = MAC;
            end
         end
         MAC: begin
            cmd.mul = 1'b1;
            if (status.last_tap) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = DONE;
         end
         DONE: begin
            // hold the sum until the result register frees up
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result word overwritten while still stalled");

   a_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == MAC))
      else $error("accepted word did not start the tap sequence");

   a_drain_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAIN) |-> $past(status.last_tap))
      else $error("drain entered before the last tap");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// ===== rtl/fir_filter_ring_core.sv =====
// Eight-tap FIR filter over a ring of the last eight samples. Each accepted
// sample overwrites the oldest slot; coefficient 7 weights the newest sample
// and coefficient 0 the oldest. The result is the exact 35-bit Q.30 sum of
// products. Samples are taken one at a time: one shared 16x16 multiplier
// steps through the eight taps one per cycle, the drain state adds the last
// product and the done state loads the result register. A result held by
// rsp_stall does not block the next sample. The user must write coefficients
// through the csr port only while the filter is idle; the block does not
// enforce it. Reset clears the ring, the write pointer and all coefficients.
module fir_filter_ring_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ffr_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ffr_pkg::ACC_W-1:0]       rsp_filtered,
   input  logic                                   csr_write_en,
   input  logic        [ffr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic signed [ffr_pkg::COEF_W-1:0]      csr_data
);

   ffr_pkg::ffr_cmd_type    cmd;
   ffr_pkg::ffr_status_type status;

   ffr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ffr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_sample),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_filtered (rsp_filtered)
   );

endmodule

// ===== tb/fir_filter_ring_core_test.sv =====
module fir_filter_ring_core_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int CSR_IDX_MAX    = (1 << ffr_pkg::CSR_IDX_W) - 1;
   localparam int MAX_REPORTS    = 10;

   typedef enum {
      COEF_ZERO, COEF_MAX, COEF_MIN, COEF_RAMP, COEF_SPIKE, COEF_RANDOM
   } coef_mode_type;
   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [ffr_pkg::SAMPLE_W-1:0] sample;
      bit                                  drain_first;
   } sample_word_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [ffr_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [ffr_pkg::ACC_W-1:0]    rsp_filtered;
   logic                                csr_write_en = 1'b0;
   logic [ffr_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic signed [ffr_pkg::COEF_W-1:0]   csr_data = '0;

   fir_filter_ring_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state mirrored on the testbench side
   logic signed [ffr_pkg::SAMPLE_W-1:0] ring_mirror [ffr_pkg::TAPS];
   logic [ffr_pkg::TAP_W-1:0]           ring_ptr;
   logic signed [ffr_pkg::COEF_W-1:0]   coef_mirror [ffr_pkg::NUM_COEFS];

   sample_word_type                  sample_queue [$];
   logic signed [ffr_pkg::ACC_W-1:0] filtered_expect [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  fail_count = 0;
   int  report_count = 0;
   int  idle_cycles = 0;
   logic req_took = 1'b0;

   function automatic logic signed [ffr_pkg::ACC_W-1:0] shift_in_and_filter(
      input logic signed [ffr_pkg::SAMPLE_W-1:0] s);
      longint acc;
      int     c;
      ring_mirror[ring_ptr] = s;
      acc = 0;
      // slot t is weighted by coefficient (TAPS-1-ptr+t) mod TAPS
      c = ffr_pkg::TAPS - 1 - int'(ring_ptr);
      for (int t = 0; t < ffr_pkg::TAPS; t++) begin
         acc += longint'(coef_mirror[c]) * longint'(ring_mirror[t]);
         c = (c + 1) % ffr_pkg::TAPS;
      end
      ring_ptr = ffr_pkg::TAP_W'((int'(ring_ptr) + 1) % ffr_pkg::TAPS);
      return acc[ffr_pkg::ACC_W-1:0];
   endfunction

   function automatic logic signed [ffr_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return ffr_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // sender: hold a stalled word, else take the next one or idle
   always @(negedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (sample_queue.size() > 0 &&
             !(sample_queue[0].drain_first && filtered_expect.size() > 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            w = sample_queue.pop_front();
            req_valid  <= 1'b1;
            req_sample <= w.sample;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      logic signed [ffr_pkg::ACC_W-1:0] want;
      logic                             accepted;
      accepted = 1'b0;
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            accepted = 1'b1;
            filtered_expect.push_back(shift_in_and_filter(req_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            accepted = 1'b1;
            if (filtered_expect.size() == 0) begin
               fail_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("unexpected result word: filtered %0d", rsp_filtered);
               end
            end else begin
               want = filtered_expect.pop_front();
               if (rsp_filtered !== want) begin
                  fail_count++;
                  if (report_count < MAX_REPORTS) begin
                     report_count++;
                     $display("filtered mismatch: expected %0d actual %0d",
                              want, rsp_filtered);
                  end
               end
            end
         end
         idle_cycles = accepted ? 0 : idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_csr(input int idx, input logic signed [ffr_pkg::COEF_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= ffr_pkg::CSR_IDX_W'(idx);
      csr_data     <= val;
      if (idx < ffr_pkg::NUM_COEFS)
         coef_mirror[idx] = val;
   endtask

   task automatic load_coefs(input coef_mode_type mode);
      int spike;
      spike = $urandom_range(ffr_pkg::NUM_COEFS - 1);
      for (int k = 0; k < ffr_pkg::NUM_COEFS; k++) begin
         case (mode)
            COEF_ZERO:   write_csr(k, 16'sh0000);
            COEF_MAX:    write_csr(k, 16'sh7fff);
            COEF_MIN:    write_csr(k, 16'sh8000);
            COEF_RAMP:   write_csr(k, ffr_pkg::COEF_W'((k % 2 ? -1 : 1) * (k + 1) * 1000));
            COEF_SPIKE:  write_csr(k, k == spike ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000)
                                                 : 16'sh0000);
            default:     write_csr(k, ffr_pkg::COEF_W'($urandom));
         endcase
      end
      // stray writes past the last coefficient must not land anywhere
      if ($urandom_range(1))
         write_csr($urandom_range(CSR_IDX_MAX, ffr_pkg::NUM_COEFS),
                   ffr_pkg::COEF_W'($urandom));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 84; stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 84; end
         default:   begin send_idle_pct = 21; stall_pct = 21; end
      endcase
   endtask

   task automatic queue_sample(input logic signed [ffr_pkg::SAMPLE_W-1:0] s,
                               input bit drain = 1'b0);
      sample_word_type w;
      w.sample = s;
      w.drain_first = drain;
      sample_queue.push_back(w);
   endtask

   // wait for every word to get through, then let the datapath go quiet
   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_valid || filtered_expect.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      coef_mode_type cmode;
      for (int k = 0; k < ffr_pkg::TAPS; k++) ring_mirror[k] = '0;
      for (int k = 0; k < ffr_pkg::NUM_COEFS; k++) coef_mirror[k] = '0;
      ring_ptr = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients are zero
      set_idling(IDLE_NONE);
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);
      wait_idle();

      // every out-of-range index once, then a ramp; an impulse shows the tap order
      for (int k = ffr_pkg::NUM_COEFS; k <= CSR_IDX_MAX; k++) write_csr(k, 16'sh7fff);
      load_coefs(COEF_RAMP);
      queue_sample(16'sh0001);
      for (int k = 0; k < ffr_pkg::TAPS - 1; k++) queue_sample(16'sh0000);
      wait_idle();

      // largest positive sum, then the largest positive sample into half the taps
      load_coefs(COEF_MIN);
      for (int k = 0; k < ffr_pkg::TAPS; k++) queue_sample(16'sh8000);
      for (int k = 0; k < ffr_pkg::TAPS / 2; k++) queue_sample(16'sh7fff);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: cmode = COEF_RANDOM;
            1: cmode = COEF_MAX;
            2: cmode = COEF_SPIKE;
            3: cmode = COEF_RANDOM;
            4: cmode = COEF_ZERO;
            5: cmode = COEF_MIN;
            6: cmode = COEF_RAMP;
            default: cmode = COEF_RANDOM;
         endcase
         load_coefs(cmode);
         set_idling(idle_mode_type'(p % 4));
         for (int i = 0; i < 100; i++)
            queue_sample(pick_sample(), (p == 2 || p == 5) && i == 50);
         wait_idle();
      end

      if (fail_count == 0 && filtered_expect.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ffr_pkg.sv
rtl/ffr_datapath.sv
rtl/ffr_ctrl.sv
rtl/fir_filter_ring_core.sv
tb/fir_filter_ring_core_test.sv
